// File: rtl/tac_pkg.sv
package tac_pkg;

    localparam int AXIS_W              = 16;
    localparam int ANGLE_W             = 16;
    localparam int SQ_W                = 32;
    localparam int ROOT_W              = 32;
    localparam int REM_W               = 36;
    localparam int XY_W                = 36;
    localparam int Z_W                 = 34;
    localparam int ATAN_W              = 30;
    localparam int CORDIC_STEPS        = 24;
    localparam int STEP_W              = 5;
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int DEG_NUM             = 18000;
    localparam int DEG_NUM_W           = 15;
    localparam int HALF_DEN            = 157;
    localparam int DEN_SHIFT           = 30;

    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // one sample with its squared components, as queued between front and back
    typedef struct packed {
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
        logic [SQ_W-1:0]          sqx;
        logic [SQ_W-1:0]          sqy;
        logic [SQ_W-1:0]          sqz;
        logic                     zero;
    } tac_item_t;

    // per-cycle commands from the sequencer to the axis lanes
    typedef struct packed {
        logic              load;
        logic              sqrt_step;
        logic              rot;
        logic              cordic_step;
        logic [STEP_W-1:0] idx;
        logic              conv1;
        logic              conv2;
    } tac_lane_ctl_t;

    // atan(2^-i) in Q30 radians
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] r;
        case (i)
            5'd0:    r = 30'd843314857;
            5'd1:    r = 30'd497837829;
            5'd2:    r = 30'd263043837;
            5'd3:    r = 30'd133525159;
            5'd4:    r = 30'd67021687;
            5'd5:    r = 30'd33543516;
            5'd6:    r = 30'd16775851;
            5'd7:    r = 30'd8388437;
            5'd8:    r = 30'd4194283;
            5'd9:    r = 30'd2097149;
            5'd10:   r = 30'd1048576;
            5'd11:   r = 30'd524288;
            5'd12:   r = 30'd262144;
            5'd13:   r = 30'd131072;
            5'd14:   r = 30'd65536;
            5'd15:   r = 30'd32768;
            5'd16:   r = 30'd16384;
            5'd17:   r = 30'd8192;
            5'd18:   r = 30'd4096;
            5'd19:   r = 30'd2048;
            5'd20:   r = 30'd1024;
            5'd21:   r = 30'd512;
            5'd22:   r = 30'd256;
            5'd23:   r = 30'd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/tac_if.sv
interface tac_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [tac_pkg::AXIS_W-1:0] accel_x;
    logic signed [tac_pkg::AXIS_W-1:0] accel_y;
    logic signed [tac_pkg::AXIS_W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface tac_out_if;
    logic                        valid;
    logic                        ready;
    logic [tac_pkg::ANGLE_W-1:0] angle_x;
    logic [tac_pkg::ANGLE_W-1:0] angle_y;
    logic [tac_pkg::ANGLE_W-1:0] angle_z;
    logic                        zero_vector;

    modport source (output valid, output angle_x, output angle_y, output angle_z,
                    output zero_vector, input ready);
    modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                    input zero_vector, output ready);
endinterface

// File: rtl/accel_tilt_angles_core.sv
// Throughput is set by the square-root recurrence (one root bit per cycle) and the
//   CORDIC unit (one iteration per cycle); the back takes no new sample until its
//   result is captured into the result register.
// The front stage and a two-entry queue absorb up to three samples while the back works.
// Reset (rst_n, asynchronous, active low) empties the queue and drops any pending result.
module accel_tilt_angles_core #(
    parameter int ANGLE_FRAC_BITS = tac_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tac_in_if.sink     sample,
    tac_out_if.source  result
);

    localparam int LIM_I = ((180 << ANGLE_FRAC_BITS) > 65535) ? 65535
                                                             : (180 << ANGLE_FRAC_BITS);
    localparam logic [tac_pkg::ANGLE_W-1:0] LIM = tac_pkg::ANGLE_W'(LIM_I);

    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_not_empty;
    tac_pkg::tac_item_t front_item;
    tac_pkg::tac_item_t head;

    // Front: register the sample, form the squares and the zero-vector flag.
    tac_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .full   (q_full),
        .push   (push),
        .item   (front_item)
    );

    // Queue: decouple classification from the long per-sample computation.
    tac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    // Back: per-axis square root, arctangent CORDIC and degree conversion,
    // three lanes in lockstep, with a result register toward the sink.
    tac_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .result      (result)
    );

    // A zero vector always reports zero angles.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.zero_vector |->
            (result.angle_x == '0) && (result.angle_y == '0) && (result.angle_z == '0))
        else $error("zero vector with nonzero angle");

    // Angles never exceed the saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            (result.angle_x <= LIM) && (result.angle_y <= LIM) && (result.angle_z <= LIM))
        else $error("angle above limit");

    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("queue overflow");

    // Nothing is popped from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_not_empty)
        else $error("queue underflow");

endmodule

// File: rtl/tac_front.sv
module tac_front (
    input  logic                clk,
    input  logic                rst_n,
    tac_in_if.sink              sample,
    input  logic                full,
    output logic                push,
    output tac_pkg::tac_item_t  item
);

    logic                              hold_valid_reg;
    logic                              hold_valid_next;
    logic signed [tac_pkg::AXIS_W-1:0] ax_reg;
    logic signed [tac_pkg::AXIS_W-1:0] ay_reg;
    logic signed [tac_pkg::AXIS_W-1:0] az_reg;
    logic                              take;

    assign sample.ready = !hold_valid_reg || !full;
    assign take         = sample.valid && sample.ready;
    assign push         = hold_valid_reg && !full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ax_reg <= sample.accel_x;
            ay_reg <= sample.accel_y;
            az_reg <= sample.accel_z;
        end
    end

    // classify: squares at full width and the all-zero flag
    always_comb
    begin
        item.ax   = ax_reg;
        item.ay   = ay_reg;
        item.az   = az_reg;
        item.sqx  = unsigned'(tac_pkg::SQ_W'(ax_reg) * tac_pkg::SQ_W'(ax_reg));
        item.sqy  = unsigned'(tac_pkg::SQ_W'(ay_reg) * tac_pkg::SQ_W'(ay_reg));
        item.sqz  = unsigned'(tac_pkg::SQ_W'(az_reg) * tac_pkg::SQ_W'(az_reg));
        item.zero = (ax_reg == '0) && (ay_reg == '0) && (az_reg == '0);
    end

endmodule

// File: rtl/tac_queue.sv
module tac_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tac_pkg::tac_item_t  push_item,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output tac_pkg::tac_item_t  head
);

    tac_pkg::tac_item_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/tac_lane.sv
module tac_lane #(
    parameter int ANGLE_FRAC_BITS = tac_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  tac_pkg::tac_lane_ctl_t            ctl,
    input  logic signed [tac_pkg::AXIS_W-1:0] axis,
    input  logic [tac_pkg::SQ_W-1:0]          perp,
    output logic [tac_pkg::ANGLE_W-1:0]       angle
);

    localparam int P_W    = tac_pkg::ROOT_W + tac_pkg::DEG_NUM_W;
    localparam int M_W    = P_W + ANGLE_FRAC_BITS - tac_pkg::DEN_SHIFT;
    localparam int K      = M_W + 9;
    localparam int R_W    = K - 7;
    localparam int Q_W    = M_W + R_W;
    localparam int QV_W   = Q_W - K;
    localparam longint RECIP_L = ((64'sd1 <<< K) + 64'sd313) / 64'sd314;
    localparam logic [R_W-1:0] RECIP = R_W'(RECIP_L);
    localparam int LIM_I  = ((180 << ANGLE_FRAC_BITS) > 65535) ? 65535
                                                              : (180 << ANGLE_FRAC_BITS);
    localparam logic [tac_pkg::ANGLE_W-1:0] LIM = tac_pkg::ANGLE_W'(LIM_I);

    logic signed [tac_pkg::AXIS_W-1:0] a_reg;
    logic [tac_pkg::SQ_W-1:0]          rad_reg;
    logic [tac_pkg::REM_W-1:0]         rem_reg;
    logic [tac_pkg::ROOT_W-1:0]        root_reg;
    logic signed [tac_pkg::XY_W-1:0]   x_reg;
    logic signed [tac_pkg::XY_W-1:0]   y_reg;
    logic signed [tac_pkg::Z_W-1:0]    z_reg;
    logic [P_W-1:0]                    p_reg;
    logic [Q_W-1:0]                    q_reg;

    logic [tac_pkg::REM_W-1:0]         rem_sh;
    logic [tac_pkg::REM_W-1:0]         trial;
    logic signed [tac_pkg::XY_W-1:0]   xa;
    logic signed [tac_pkg::XY_W-1:0]   yr;
    logic signed [tac_pkg::XY_W-1:0]   dx;
    logic signed [tac_pkg::XY_W-1:0]   dy;
    logic signed [tac_pkg::Z_W-1:0]    at;
    logic [tac_pkg::ROOT_W-1:0]        zc;
    logic [P_W+ANGLE_FRAC_BITS-1:0]    pt;
    logic [M_W-1:0]                    m;
    logic [QV_W-1:0]                   qv;

    // one root bit per cycle, two radicand bits pulled in each step
    assign rem_sh = {rem_reg[tac_pkg::REM_W-3:0], rad_reg[tac_pkg::SQ_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    assign xa = {{(tac_pkg::XY_W-tac_pkg::AXIS_W-16){a_reg[tac_pkg::AXIS_W-1]}},
                 a_reg, 16'h0000};
    assign yr = signed'({{(tac_pkg::XY_W-tac_pkg::ROOT_W){1'b0}}, root_reg});
    assign dx = y_reg >>> ctl.idx;
    assign dy = x_reg >>> ctl.idx;
    assign at = signed'({{(tac_pkg::Z_W-tac_pkg::ATAN_W){1'b0}},
                         tac_pkg::atan_q30(ctl.idx)});

    assign zc = z_reg[tac_pkg::Z_W-1] ? '0 : z_reg[tac_pkg::ROOT_W-1:0];
    assign pt = {p_reg, {ANGLE_FRAC_BITS{1'b0}}};
    assign m  = M_W'(pt >> tac_pkg::DEN_SHIFT) + M_W'(tac_pkg::HALF_DEN);
    assign qv = q_reg[Q_W-1:K];

    always_comb
    begin
        if ({{tac_pkg::ANGLE_W{1'b0}}, qv} > (QV_W+tac_pkg::ANGLE_W)'(LIM_I))
        begin
            angle = LIM;
        end
        else
        begin
            angle = tac_pkg::ANGLE_W'(qv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            a_reg    <= axis;
            rad_reg  <= perp;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (ctl.sqrt_step)
        begin
            rad_reg <= {rad_reg[tac_pkg::SQ_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[tac_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[tac_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        if (ctl.rot)
        begin
            // negative axis: pre-rotate the vector by -90 degrees and start the angle at +90
            if (a_reg[tac_pkg::AXIS_W-1])
            begin
                x_reg <= yr;
                y_reg <= -xa;
                z_reg <= tac_pkg::HALF_PI_Q30;
            end
            else
            begin
                x_reg <= xa;
                y_reg <= yr;
                z_reg <= '0;
            end
        end
        else if (ctl.cordic_step)
        begin
            if (!y_reg[tac_pkg::XY_W-1])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
        end

        if (ctl.conv1)
        begin
            p_reg <= P_W'(zc) * P_W'(tac_pkg::DEG_NUM);
        end
        if (ctl.conv2)
        begin
            // divide by 314 through a reciprocal multiply
            q_reg <= Q_W'(m) * Q_W'(RECIP);
        end
    end

endmodule

// File: rtl/tac_back.sv
module tac_back #(
    parameter int ANGLE_FRAC_BITS = tac_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  tac_pkg::tac_item_t  head,
    output logic                pop,
    tac_out_if.source           result
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQRT   = 7'b0000010,
        ST_ROT    = 7'b0000100,
        ST_CORDIC = 7'b0001000,
        ST_CONV1  = 7'b0010000,
        ST_CONV2  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } tac_state_t;

    localparam logic [tac_pkg::STEP_W-1:0] SQRT_LAST   = tac_pkg::STEP_W'(tac_pkg::ROOT_W - 1);
    localparam logic [tac_pkg::STEP_W-1:0] CORDIC_LAST =
        tac_pkg::STEP_W'(tac_pkg::CORDIC_STEPS - 1);

    tac_state_t                    state_reg;
    tac_state_t                    state_next;
    logic [tac_pkg::STEP_W-1:0]    cnt_reg;
    logic [tac_pkg::STEP_W-1:0]    cnt_next;
    logic                          zero_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [tac_pkg::ANGLE_W-1:0]   ang_x_reg;
    logic [tac_pkg::ANGLE_W-1:0]   ang_y_reg;
    logic [tac_pkg::ANGLE_W-1:0]   ang_z_reg;
    logic                          zv_reg;
    logic                          capture;
    tac_pkg::tac_lane_ctl_t        ctl;
    logic [tac_pkg::SQ_W-1:0]      perp_x;
    logic [tac_pkg::SQ_W-1:0]      perp_y;
    logic [tac_pkg::SQ_W-1:0]      perp_z;
    logic [tac_pkg::ANGLE_W-1:0]   lane_x;
    logic [tac_pkg::ANGLE_W-1:0]   lane_y;
    logic [tac_pkg::ANGLE_W-1:0]   lane_z;

    // |v|^2 - a^2 is the sum of the other two squares
    assign perp_x = head.sqy + head.sqz;
    assign perp_y = head.sqx + head.sqz;
    assign perp_z = head.sqx + head.sqy;

    assign result.valid       = out_valid_reg;
    assign result.angle_x     = ang_x_reg;
    assign result.angle_y     = ang_y_reg;
    assign result.angle_z     = ang_z_reg;
    assign result.zero_vector = zv_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pop             = 1'b0;
        capture         = 1'b0;
        ctl             = '0;
        ctl.idx         = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop        = 1'b1;
                    ctl.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                ctl.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                ctl.rot    = 1'b1;
                cnt_next   = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                ctl.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == CORDIC_LAST)
                begin
                    state_next = ST_CONV1;
                end
            end
            ST_CONV1:
            begin
                ctl.conv1  = 1'b1;
                state_next = ST_CONV2;
            end
            ST_CONV2:
            begin
                ctl.conv2  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    capture    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            zero_reg <= head.zero;
        end
        if (capture)
        begin
            ang_x_reg <= zero_reg ? '0 : lane_x;
            ang_y_reg <= zero_reg ? '0 : lane_y;
            ang_z_reg <= zero_reg ? '0 : lane_z;
            zv_reg    <= zero_reg;
        end
    end

    tac_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_x (
        .clk   (clk),
        .ctl   (ctl),
        .axis  (head.ax),
        .perp  (perp_x),
        .angle (lane_x)
    );

    tac_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_y (
        .clk   (clk),
        .ctl   (ctl),
        .axis  (head.ay),
        .perp  (perp_y),
        .angle (lane_y)
    );

    tac_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_z (
        .clk   (clk),
        .ctl   (ctl),
        .axis  (head.az),
        .perp  (perp_z),
        .angle (lane_z)
    );

endmodule
